/* rtl/amgs_pkg.sv */
// shared types and constants for the adjacency matrix graph store
`default_nettype none

package amgs_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VERT_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] OP_ADD_EDGE = 2'd0;
    localparam logic [1:0] OP_LIST     = 2'd1;
    localparam logic [1:0] OP_DEGREES  = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] KIND_NEIGHBOR = 2'd0;
    localparam logic [1:0] KIND_DEGREES  = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;
    localparam logic [1:0] KIND_EMPTY    = 2'd3;

    typedef logic [MAX_VERTICES-1:0] row_t;
    typedef logic [VERT_W-1:0]       vert_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] first_vertex;
        logic [5:0] second_vertex;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [5:0] neighbor;
        logic [6:0] out_degree;
        logic [6:0] in_degree;
        logic       last;
    } rsp_word_t;

    typedef struct packed {
        logic  rd_en;
        vert_t rd_addr;
        logic  wr_en;
        vert_t wr_addr;
        row_t  wr_row;
    } row_req_t;

endpackage

`default_nettype wire

/* rtl/adjacency_matrix_graph_store.sv */
// adjacency matrix graph store top level: command sequencer and result register
// add edge: read-modify-write of both rows (states WA then WB), no result word
// neighbor list and degree query: row read (LOAD), then one row bit a cycle unless the result output stalls;
// list gives one result word per set bit (an empty word if none), degrees gives a single word
// index or opcode error: a single error word, loaded in state ERR once the output is free; one command at a time
// rst_n clears control, row valid bits and sets vertex_count to 64; no clearing pass
`default_nettype none

module adjacency_matrix_graph_store (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cmd_valid,
    output logic                  cmd_stall,
    input  amgs_pkg::cmd_word_t   cmd,
    output logic                  rsp_valid,
    input  wire                   rsp_stall,
    output amgs_pkg::rsp_word_t   rsp,
    input  wire                   cfg_we,
    input  wire [6:0]             cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ERR  = 3'd1;
    localparam logic [2:0] ST_WA   = 3'd2;
    localparam logic [2:0] ST_WB   = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_SCAN = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    amgs_pkg::vert_t      a_reg, a_next;
    amgs_pkg::vert_t      b_reg, b_next;
    amgs_pkg::row_t       row_reg, row_next;
    amgs_pkg::vert_t      j_reg, j_next;
    amgs_pkg::cnt_t       cnt_reg, cnt_next;
    logic [6:0]           vc_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    amgs_pkg::rsp_word_t  rsp_reg, rsp_next;
    logic                 rsp_load;

    amgs_pkg::row_req_t   req;
    amgs_pkg::row_t       rd_data;
    amgs_pkg::cnt_t       n_eff;
    amgs_pkg::row_t       lim_mask;
    logic                 out_free;
    logic                 cmd_fire;
    logic                 cmd_bad;
    logic                 nb_last;

    amgs_row_store u_rows (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    // effective vertex count, clamped to the matrix size
    always_comb
    begin
        if (vc_reg > amgs_pkg::cnt_t'(amgs_pkg::MAX_VERTICES))
        begin
            n_eff = amgs_pkg::cnt_t'(amgs_pkg::MAX_VERTICES);
        end
        else
        begin
            n_eff = vc_reg;
        end
        if (n_eff == amgs_pkg::cnt_t'(amgs_pkg::MAX_VERTICES))
        begin
            lim_mask = '1;
        end
        else
        begin
            lim_mask = (amgs_pkg::row_t'(1) << n_eff[amgs_pkg::VERT_W-1:0])
                       - amgs_pkg::row_t'(1);
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign cmd_bad   = (cmd.opcode == amgs_pkg::OP_RESERVED)
                    || ({1'b0, cmd.first_vertex} >= n_eff)
                    || ((cmd.opcode == amgs_pkg::OP_ADD_EDGE)
                        && ({1'b0, cmd.second_vertex} >= n_eff));
    assign nb_last   = ((row_reg >> 1) == '0);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        req        = '0;
        rsp_load   = 1'b0;
        rsp_next   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next = cmd.opcode;
                    a_next  = cmd.first_vertex;
                    b_next  = cmd.second_vertex;
                    if (cmd_bad)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = cmd.first_vertex;
                        state_next  = (cmd.opcode == amgs_pkg::OP_ADD_EDGE) ? ST_WA : ST_LOAD;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    rsp_load             = 1'b1;
                    rsp_next.result_kind = amgs_pkg::KIND_ERROR;
                    rsp_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_WA:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = a_reg;
                req.wr_row  = rd_data | (amgs_pkg::row_t'(1) << b_reg);
                req.rd_en   = 1'b1;
                req.rd_addr = b_reg;
                state_next  = ST_WB;
            end
            ST_WB:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = b_reg;
                req.wr_row  = rd_data | (amgs_pkg::row_t'(1) << a_reg);
                state_next  = ST_IDLE;
            end
            ST_LOAD:
            begin
                // matrix stays symmetric, so the row also gives the column
                row_next   = rd_data & lim_mask;
                j_next     = '0;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (op_reg == amgs_pkg::OP_LIST)
                begin
                    if (row_reg == '0)
                    begin
                        if (out_free)
                        begin
                            rsp_load             = 1'b1;
                            rsp_next.result_kind = amgs_pkg::KIND_EMPTY;
                            rsp_next.last        = 1'b1;
                            state_next           = ST_IDLE;
                        end
                    end
                    else if (row_reg[0])
                    begin
                        if (out_free)
                        begin
                            rsp_load             = 1'b1;
                            rsp_next.result_kind = amgs_pkg::KIND_NEIGHBOR;
                            rsp_next.neighbor    = j_reg;
                            rsp_next.last        = nb_last;
                            row_next             = row_reg >> 1;
                            j_next               = j_reg + amgs_pkg::vert_t'(1);
                            if (nb_last)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        row_next = row_reg >> 1;
                        j_next   = j_reg + amgs_pkg::vert_t'(1);
                    end
                end
                else
                begin
                    if (row_reg == '0)
                    begin
                        if (out_free)
                        begin
                            rsp_load             = 1'b1;
                            rsp_next.result_kind = amgs_pkg::KIND_DEGREES;
                            rsp_next.out_degree  = cnt_reg;
                            rsp_next.in_degree   = cnt_reg;
                            rsp_next.last        = 1'b1;
                            state_next           = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + amgs_pkg::cnt_t'(row_reg[0]);
                        row_next = row_reg >> 1;
                        j_next   = j_reg + amgs_pkg::vert_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            vc_reg        <= 7'(amgs_pkg::MAX_VERTICES);
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        row_reg <= row_next;
        j_reg   <= j_next;
        cnt_reg <= cnt_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // symmetric matrix gives equal row and column counts
    a_deg_equal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == amgs_pkg::KIND_DEGREES)
        |-> rsp.out_degree == rsp.in_degree)
        else $error("degree word with unequal counts");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load && rsp_next.last |=> state_reg == ST_IDLE)
        else $error("sequencer busy after final word");

    a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> state_reg != ST_IDLE)
        else $error("accepted command left no work");

    a_no_word_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WA) || (state_reg == ST_WB) |-> !rsp_load)
        else $error("add edge produced a word");

endmodule

`default_nettype wire

/* rtl/amgs_row_store.sv */
// edge matrix row memory with per-row valid bits and registered read
`default_nettype none

module amgs_row_store (
    input  wire                 clk,
    input  wire                 rst_n,
    input  amgs_pkg::row_req_t  req,
    output amgs_pkg::row_t      rd_data
);

    amgs_pkg::row_t                      mem [amgs_pkg::MAX_VERTICES];
    logic [amgs_pkg::MAX_VERTICES-1:0]   row_valid_reg;
    amgs_pkg::row_t                      rd_row_reg;
    logic                                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_row;
        end
        if (req.rd_en)
        begin
            rd_row_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                row_valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[req.rd_addr];
            end
        end
    end

    // a row never written reads as no edges
    assign rd_data = rd_valid_reg ? rd_row_reg : '0;

endmodule

`default_nettype wire

/* verif/adjacency_matrix_graph_store_tb.sv */
// testbench for adjacency_matrix_graph_store: queued command words, predictor, result checks
`timescale 1ns / 1ps

module adjacency_matrix_graph_store_tb;
    import amgs_pkg::*;

    localparam int SETTLE_CYCLES = 100;

    typedef enum logic [1:0] {STEP_WORD, STEP_CONFIG, STEP_SETTLE} step_kind_t;

    typedef struct {
        step_kind_t kind;
        cmd_word_t  word;
        logic [6:0] value;
    } step_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    cmd_word_t  cmd = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_word_t  rsp;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_data = '0;

    step_t       steps [$];
    rsp_word_t   expected_words [$];
    row_t        link_rows [MAX_VERTICES];
    cnt_t        vertex_limit;
    logic        results_owed = 1'b0;
    logic        stimulus_done = 1'b0;
    int          mismatch_count = 0;
    int          plan_limit = MAX_VERTICES;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned settle_count = 0;
    bit          steady_source = 1'b0;
    bit          steady_sink = 1'b0;

    adjacency_matrix_graph_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int unsigned pause_len(inout bit steady);
        int unsigned roll;
        if ($urandom_range(39) == 0)
            steady = !steady;
        if (steady)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic rsp_word_t result_word(logic [1:0] kind, vert_t nb, cnt_t od, cnt_t id,
                                              logic is_last);
        rsp_word_t r;
        r.result_kind = kind;
        r.neighbor    = nb;
        r.out_degree  = od;
        r.in_degree   = id;
        r.last        = is_last;
        return r;
    endfunction

    function automatic void predict_results(cmd_word_t w);
        int    n;
        int    j;
        int    last_hit;
        cnt_t  out_count;
        cnt_t  in_count;
        vert_t a;
        vert_t b;
        a = w.first_vertex;
        b = w.second_vertex;
        n = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_limit);
        if (w.opcode == OP_ADD_EDGE)
        begin
            if (a >= n || b >= n)
                expected_words.push_back(result_word(KIND_ERROR, '0, '0, '0, 1'b1));
            else
            begin
                link_rows[a][b] = 1'b1;
                link_rows[b][a] = 1'b1;
            end
        end
        else if (w.opcode == OP_RESERVED || a >= n)
            expected_words.push_back(result_word(KIND_ERROR, '0, '0, '0, 1'b1));
        else if (w.opcode == OP_LIST)
        begin
            last_hit = -1;
            for (j = 0; j < n; j++)
                if (link_rows[a][j] && link_rows[j][a])
                    last_hit = j;
            if (last_hit < 0)
                expected_words.push_back(result_word(KIND_EMPTY, '0, '0, '0, 1'b1));
            else
                for (j = 0; j <= last_hit; j++)
                    if (link_rows[a][j] && link_rows[j][a])
                        expected_words.push_back(result_word(KIND_NEIGHBOR, vert_t'(j), '0, '0,
                                                             j == last_hit));
        end
        else
        begin
            out_count = '0;
            in_count = '0;
            for (j = 0; j < n; j++)
            begin
                out_count += link_rows[a][j];
                in_count += link_rows[j][a];
            end
            expected_words.push_back(result_word(KIND_DEGREES, '0, out_count, in_count, 1'b1));
        end
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [6:0] got, logic [6:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // driver: one step from the queue per free cycle, once any random gap has run out
    always @(posedge clk or negedge rst_n)
    begin
        logic      next_valid;
        cmd_word_t next_word;
        logic      next_we;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd <= '0;
            cfg_we <= 1'b0;
            cfg_data <= '0;
            stimulus_done <= 1'b0;
            gap_left = 0;
            settle_count = 0;
        end
        else
        begin
            next_valid = cmd_valid && cmd_stall;
            next_word = cmd;
            next_we = 1'b0;
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (steps.size() != 0)
                begin
                    case (steps[0].kind)
                        STEP_WORD:
                        begin
                            next_valid = 1'b1;
                            next_word = steps[0].word;
                            void'(steps.pop_front());
                            gap_left = pause_len(steady_source);
                        end
                        STEP_CONFIG:
                        begin
                            next_we = 1'b1;
                            cfg_data <= steps[0].value;
                            void'(steps.pop_front());
                        end
                        default:
                        begin
                            // wait for every owed word, then let the block go quiet
                            if (results_owed)
                                settle_count = 0;
                            else if (settle_count >= SETTLE_CYCLES)
                            begin
                                settle_count = 0;
                                void'(steps.pop_front());
                            end
                            else
                                settle_count++;
                        end
                    endcase
                end
            end
            cmd_valid <= next_valid;
            cmd <= next_word;
            cfg_we <= next_we;
            stimulus_done <= (steps.size() == 0) && !next_valid;
        end
    end

    // monitor: predicts on accepted commands, checks accepted result words, drives stall
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t want;
        int        r;
        if (!rst_n)
        begin
            for (r = 0; r < MAX_VERTICES; r++)
                link_rows[r] = '0;
            vertex_limit = cnt_t'(MAX_VERTICES);
            hold_left = 0;
            rsp_stall <= 1'b0;
            results_owed <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                vertex_limit = cfg_data;
            if (cmd_valid && !cmd_stall)
                predict_results(cmd);
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word, kind %0d", rsp.result_kind));
                else
                begin
                    want = expected_words.pop_front();
                    check_field("result_kind", rsp.result_kind, want.result_kind);
                    check_field("neighbor", rsp.neighbor, want.neighbor);
                    check_field("out_degree", rsp.out_degree, want.out_degree);
                    check_field("in_degree", rsp.in_degree, want.in_degree);
                    check_field("last", rsp.last, want.last);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                hold_left = ($urandom_range(2) == 0) ? pause_len(steady_sink) : 0;
                rsp_stall <= (hold_left != 0);
            end
            results_owed <= (expected_words.size() != 0);
        end
    end

    task automatic queue_word(logic [1:0] op, int a, int b);
        step_t s;
        s.kind = STEP_WORD;
        s.word.opcode = op;
        s.word.first_vertex = vert_t'(a);
        s.word.second_vertex = vert_t'(b);
        s.value = '0;
        steps.push_back(s);
    endtask

    task automatic queue_settle();
        step_t s;
        s.kind = STEP_SETTLE;
        s.word = '0;
        s.value = '0;
        steps.push_back(s);
    endtask

    task automatic queue_config(int v);
        step_t s;
        queue_settle();
        s.kind = STEP_CONFIG;
        s.word = '0;
        s.value = v[6:0];
        steps.push_back(s);
        plan_limit = (v > MAX_VERTICES) ? MAX_VERTICES : v;
    endtask

    task automatic queue_random(int count);
        cmd_word_t   w;
        int unsigned roll;
        int          hot;
        repeat (count)
        begin
            w.opcode = $urandom_range(3);
            w.first_vertex = $urandom_range(63);
            w.second_vertex = $urandom_range(63);
            roll = $urandom_range(99);
            if (roll >= 10 && plan_limit > 0)
            begin
                w.opcode = (roll < 60) ? OP_ADD_EDGE : ((roll < 82) ? OP_LIST : OP_DEGREES);
                // a small hot region keeps neighbor lists from staying empty
                hot = ($urandom_range(1) == 0 && plan_limit > 8) ? 8 : plan_limit;
                w.first_vertex = $urandom_range(hot - 1);
                w.second_vertex = $urandom_range(hot - 1);
                if (plan_limit < MAX_VERTICES && $urandom_range(11) == 0)
                begin
                    if ($urandom_range(1) == 0)
                        w.first_vertex = $urandom_range(63, plan_limit);
                    else
                        w.second_vertex = $urandom_range(63, plan_limit);
                end
            end
            queue_word(w.opcode, w.first_vertex, w.second_vertex);
        end
    endtask

    initial
    begin
        int hub;
        int j;
        // empty graph, self loop, reserved opcode
        queue_word(OP_LIST, 0, 0);
        queue_word(OP_DEGREES, 63, 0);
        queue_word(OP_ADD_EDGE, 0, 63);
        queue_word(OP_ADD_EDGE, 63, 63);
        queue_word(OP_ADD_EDGE, 5, 0);
        queue_word(OP_LIST, 63, 0);
        queue_word(OP_LIST, 0, 0);
        queue_word(OP_DEGREES, 63, 0);
        queue_word(OP_RESERVED, 63, 63);
        // vertex count of one
        queue_config(1);
        queue_word(OP_ADD_EDGE, 0, 0);
        queue_word(OP_ADD_EDGE, 0, 1);
        queue_word(OP_LIST, 0, 0);
        queue_word(OP_LIST, 1, 0);
        queue_word(OP_DEGREES, 0, 0);
        // zero vertices
        queue_config(0);
        queue_word(OP_ADD_EDGE, 0, 0);
        queue_word(OP_LIST, 0, 0);
        // lowered count hides stored edges
        queue_config(6);
        queue_word(OP_ADD_EDGE, 6, 0);
        queue_word(OP_ADD_EDGE, 0, 6);
        queue_word(OP_LIST, 0, 0);
        queue_word(OP_DEGREES, 0, 0);
        queue_word(OP_DEGREES, 6, 0);
        // count above matrix size
        queue_config(127);
        queue_word(OP_LIST, 63, 0);

        // full row: one list gives every vertex
        hub = $urandom_range(63);
        for (j = 0; j < MAX_VERTICES; j++)
        begin
            if ($urandom_range(1) == 0)
                queue_word(OP_ADD_EDGE, hub, j);
            else
                queue_word(OP_ADD_EDGE, j, hub);
        end
        queue_word(OP_LIST, hub, 0);
        queue_word(OP_DEGREES, hub, 0);

        queue_random(6);
        queue_settle();
        queue_random(4);
        queue_config(9);
        queue_random(6);
        queue_config(2);
        queue_random(4);
        queue_config(64);
        queue_random(4);
        queue_config($urandom_range(64, 1));
        queue_random(4);
        queue_config(33);
        queue_random(4);
        queue_settle();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (stimulus_done);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #80ms;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/amgs_pkg.sv
rtl/amgs_row_store.sv
rtl/adjacency_matrix_graph_store.sv
verif/adjacency_matrix_graph_store_tb.sv
